// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, codes and widths of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int FIELD_W = 16;             // width of an operand field on the bus
	localparam int OPW     = 16;             // operand bits in use, sign at the top
	localparam int PW      = 2 * OPW;        // product magnitude
	localparam int NW      = PW + 1;         // sum magnitude, gcd and divider width
	localparam int KW      = $clog2(NW + 1); // shift and bit counters
	localparam int RNUM_W  = 33;
	localparam int RDEN_W  = 31;
	localparam int FUNC_W  = 4;
	localparam int ERR_W   = 2;
	localparam int IN_W    = 4 * FIELD_W;
	localparam int OUT_RAW = RNUM_W + RDEN_W + 1 + ERR_W;
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

	localparam logic [FUNC_W-1:0] FN_ADD    = 4'd0;
	localparam logic [FUNC_W-1:0] FN_SUB    = 4'd1;
	localparam logic [FUNC_W-1:0] FN_MUL    = 4'd2;
	localparam logic [FUNC_W-1:0] FN_DIV    = 4'd3;
	localparam logic [FUNC_W-1:0] FN_EQ     = 4'd4;
	localparam logic [FUNC_W-1:0] FN_NE     = 4'd5;
	localparam logic [FUNC_W-1:0] FN_LT     = 4'd6;
	localparam logic [FUNC_W-1:0] FN_GT     = 4'd7;
	localparam logic [FUNC_W-1:0] FN_REDUCE = 4'd8;

	localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_DEN_ZERO = 2'd1;
	localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_GCD,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic sum;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic mul_last;
		logic early;
		logic gcd_done;
		logic div_last;
		logic out_full;
	} stat_t;

endpackage

// ===== rtl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add, sub, mul, div, compare and reduce of two signed fractions.
// ----------------------------------------------------------------------------
// channel   dir  tdata                                     tuser
// s_axis    in   a_num, a_den, b_num, b_den (16 b each)    func
// m_axis    out  res_num, res_den, flag, error, pad to 72  -
//
// One request at a time: three products on the shared 16x16 multiplier, a sum,
// a binary gcd loop, a bit-serial restoring divide, then the output register.
// Compares, errors and unknown codes skip gcd and divide; fractions spend
// most of their time in the gcd loop and the bit-serial divider.
// Reset clears the sequencer and the output valid; a stalled result holds in
// the output register while the next request is taken and worked on.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [rau_pkg::IN_W-1:0]   s_axis_tdata,  // a_num, a_den, b_num, b_den
	input  logic [rau_pkg::FUNC_W-1:0] s_axis_tuser,  // func
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [rau_pkg::OUT_W-1:0]  m_axis_tdata   // res_num, res_den, flag, error
);
	import rau_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	rau_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	rau_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== rtl/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: load, three products, sum, binary gcd, division, result.
// ----------------------------------------------------------------------------
module rau_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  rau_pkg::stat_t stat,
	output rau_pkg::cmd_t  cmd
);
	import rau_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_nx = ST_MUL;
			end
			ST_MUL: begin
				if (stat.mul_last) state_nx = ST_SUM;
			end
			ST_SUM: begin
				state_nx = stat.early ? ST_OUT : ST_GCD;
			end
			ST_GCD: begin
				if (stat.gcd_done) state_nx = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_last) state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (!stat.out_full) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd           = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.load      = s_axis_tvalid;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
			end
			ST_GCD: begin
				cmd.gcd_step = !stat.gcd_done;
				cmd.div_init = stat.gcd_done;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_OUT: begin
				cmd.out_load = !stat.out_full;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/rau_dp.sv =====
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: sign-magnitude operands, shared multiplier, binary gcd,
// twin restoring dividers and the result register.
// ----------------------------------------------------------------------------
module rau_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rau_pkg::cmd_t              cmd,
	output rau_pkg::stat_t             stat,
	input  logic [rau_pkg::IN_W-1:0]   s_axis_tdata,
	input  logic [rau_pkg::FUNC_W-1:0] s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [rau_pkg::OUT_W-1:0]  m_axis_tdata
);
	import rau_pkg::*;

	function automatic logic [OPW-1:0] mag_of(input logic [OPW-1:0] v);
		return v[OPW-1] ? (~v + 1'b1) : v;
	endfunction

	localparam logic [OPW-1:0] ONE = OPW'(1);

	logic [FUNC_W-1:0] func_q;
	logic [OPW-1:0]    an_mag_q, ad_mag_q, bn_mag_q, bd_mag_q;
	logic              an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;

	logic [1:0]    mul_cnt_q;
	logic [PW-1:0] p_mag_q [3];
	logic          p_neg_q [3];

	logic [NW-1:0] n_mag_q;
	logic          n_neg_q;
	logic [NW-1:0] u_q, v_q, g_q;
	logic [KW-1:0] k_q, div_cnt_q;
	logic [NW-1:0] qn_q, qd_q;
	logic [NW:0]   rn_q, rd_q;

	logic [RNUM_W-1:0] res_num_q;
	logic [RDEN_W-1:0] res_den_q;
	logic              flag_q;
	logic [ERR_W-1:0]  err_q;
	logic              out_valid_q;

	// operand decode
	logic is_frac, is_cmp;
	logic [ERR_W-1:0] err_c;
	always_comb begin
		is_frac = (func_q == FN_ADD) || (func_q == FN_SUB) || (func_q == FN_MUL) ||
			(func_q == FN_DIV) || (func_q == FN_REDUCE);
		is_cmp  = (func_q == FN_EQ) || (func_q == FN_NE) || (func_q == FN_LT) ||
			(func_q == FN_GT);
		err_c   = ERR_NONE;
		if (is_frac || is_cmp) begin
			if (ad_mag_q == '0 || (func_q != FN_REDUCE && bd_mag_q == '0))
				err_c = ERR_DEN_ZERO;
			else if (func_q == FN_DIV && bn_mag_q == '0)
				err_c = ERR_DIV_ZERO;
		end
	end

	// product select: cross terms, second term negated for sub and compares
	logic [OPW-1:0] x_mag, y_mag;
	logic           x_neg, y_neg, inv;
	logic [PW-1:0]  prod;
	always_comb begin
		x_mag = an_mag_q;
		x_neg = an_neg_q;
		y_mag = bd_mag_q;
		y_neg = bd_neg_q;
		inv   = 1'b0;
		case (mul_cnt_q)
			2'd0: begin
				if (func_q == FN_MUL) begin
					y_mag = bn_mag_q;
					y_neg = bn_neg_q;
				end else if (func_q == FN_REDUCE) begin
					y_mag = ONE;
					y_neg = 1'b0;
				end
			end
			2'd1: begin
				x_mag = bn_mag_q;
				x_neg = bn_neg_q;
				y_mag = is_cmp || func_q == FN_ADD || func_q == FN_SUB ? ad_mag_q : '0;
				y_neg = ad_neg_q;
				inv   = is_cmp || func_q == FN_SUB;
			end
			default: begin
				x_mag = ad_mag_q;
				x_neg = ad_neg_q;
				if (func_q == FN_REDUCE) begin
					y_mag = ONE;
					y_neg = 1'b0;
				end else if (func_q == FN_DIV) begin
					y_mag = bn_mag_q;
					y_neg = bn_neg_q;
				end
			end
		endcase
		prod = {{OPW{1'b0}}, x_mag} * {{OPW{1'b0}}, y_mag};
	end

	// signed-magnitude sum of the two numerator terms
	logic [NW-1:0] s_mag, t0, t1;
	logic          s_neg;
	always_comb begin
		t0 = {1'b0, p_mag_q[0]};
		t1 = {1'b0, p_mag_q[1]};
		if (p_neg_q[0] == p_neg_q[1]) begin
			s_mag = t0 + t1;
			s_neg = p_neg_q[0];
		end else if (t0 >= t1) begin
			s_mag = t0 - t1;
			s_neg = p_neg_q[0];
		end else begin
			s_mag = t1 - t0;
			s_neg = p_neg_q[1];
		end
		if (s_mag == '0) s_neg = 1'b0;
	end

	// binary gcd step
	logic [NW-1:0] u_nx, v_nx;
	logic [KW-1:0] k_nx;
	always_comb begin
		u_nx = u_q;
		v_nx = v_q;
		k_nx = k_q;
		if (!u_q[0] && !v_q[0]) begin
			u_nx = u_q >> 1;
			v_nx = v_q >> 1;
			k_nx = k_q + 1'b1;
		end else if (!u_q[0]) begin
			u_nx = u_q >> 1;
		end else if (!v_q[0]) begin
			v_nx = v_q >> 1;
		end else if (u_q >= v_q) begin
			u_nx = (u_q - v_q) >> 1;
		end else begin
			v_nx = (v_q - u_q) >> 1;
		end
	end

	// restoring divide step, both dividends share the divisor
	logic [NW:0]   rn_sh, rd_sh, g_ext;
	logic          n_ge, d_ge;
	always_comb begin
		g_ext = {1'b0, g_q};
		rn_sh = {rn_q[NW-1:0], qn_q[NW-1]};
		rd_sh = {rd_q[NW-1:0], qd_q[NW-1]};
		n_ge  = rn_sh >= g_ext;
		d_ge  = rd_sh >= g_ext;
	end

	// result fields
	logic              frac_neg, cmp_neg, cmp_zero, flag_c;
	logic [RNUM_W-1:0] num_c;
	logic [RDEN_W-1:0] den_c;
	always_comb begin
		frac_neg = (n_neg_q != p_neg_q[2]) && (qn_q != '0);
		cmp_zero = (n_mag_q == '0);
		cmp_neg  = n_neg_q != (ad_neg_q != bd_neg_q);
		case (func_q)
			FN_EQ:   flag_c = cmp_zero;
			FN_NE:   flag_c = !cmp_zero;
			FN_LT:   flag_c = !cmp_zero && cmp_neg;
			FN_GT:   flag_c = !cmp_zero && !cmp_neg;
			default: flag_c = 1'b0;
		endcase
		num_c = '0;
		den_c = '0;
		if (err_c != ERR_NONE) begin
			flag_c = 1'b0;
		end else if (is_frac) begin
			num_c = frac_neg ? RNUM_W'(~qn_q + 1'b1) : RNUM_W'(qn_q);
			den_c = qd_q[RDEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_cnt_q   <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				mul_cnt_q <= '0;
			else if (cmd.mul)
				mul_cnt_q <= mul_cnt_q + 1'b1;
			if (cmd.div_init)
				div_cnt_q <= '0;
			else if (cmd.div_step)
				div_cnt_q <= div_cnt_q + 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= s_axis_tuser;
			an_mag_q <= mag_of(s_axis_tdata[0*FIELD_W +: OPW]);
			ad_mag_q <= mag_of(s_axis_tdata[1*FIELD_W +: OPW]);
			bn_mag_q <= mag_of(s_axis_tdata[2*FIELD_W +: OPW]);
			bd_mag_q <= mag_of(s_axis_tdata[3*FIELD_W +: OPW]);
			an_neg_q <= s_axis_tdata[0*FIELD_W + OPW - 1];
			ad_neg_q <= s_axis_tdata[1*FIELD_W + OPW - 1];
			bn_neg_q <= s_axis_tdata[2*FIELD_W + OPW - 1];
			bd_neg_q <= s_axis_tdata[3*FIELD_W + OPW - 1];
		end
		if (cmd.mul) begin
			p_mag_q[mul_cnt_q] <= prod;
			p_neg_q[mul_cnt_q] <= (x_neg ^ y_neg ^ inv) && (prod != '0);
		end
		if (cmd.sum) begin
			n_mag_q <= s_mag;
			n_neg_q <= s_neg;
			u_q     <= s_mag;
			v_q     <= {1'b0, p_mag_q[2]};
			k_q     <= '0;
		end
		if (cmd.gcd_step) begin
			u_q <= u_nx;
			v_q <= v_nx;
			k_q <= k_nx;
		end
		if (cmd.div_init) begin
			g_q  <= v_q << k_q;
			qn_q <= n_mag_q;
			qd_q <= {1'b0, p_mag_q[2]};
			rn_q <= '0;
			rd_q <= '0;
		end
		if (cmd.div_step) begin
			rn_q <= n_ge ? rn_sh - g_ext : rn_sh;
			rd_q <= d_ge ? rd_sh - g_ext : rd_sh;
			qn_q <= {qn_q[NW-2:0], n_ge};
			qd_q <= {qd_q[NW-2:0], d_ge};
		end
		if (cmd.out_load) begin
			res_num_q <= num_c;
			res_den_q <= den_c;
			flag_q    <= flag_c;
			err_q     <= err_c;
		end
	end

	always_comb begin
		stat.mul_last = (mul_cnt_q == 2'd2);
		stat.early    = (err_c != ERR_NONE) || !is_frac;
		stat.gcd_done = (u_q == '0);
		stat.div_last = (div_cnt_q == KW'(NW - 1));
		stat.out_full = out_valid_q && !m_axis_tready;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W - OUT_RAW){1'b0}}, err_q, flag_q, res_den_q, res_num_q};

`ifndef SYNTHESIS
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.mul, cmd.sum, cmd.gcd_step, cmd.div_init,
			cmd.div_step, cmd.out_load}))
		else $error("more than one datapath command at once");
	a_gcd_v: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gcd_step |-> v_q != '0)
		else $error("gcd lost its nonzero operand");
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rn_q < g_ext && rd_q < g_ext)
		else $error("divider remainder not below divisor");
	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && is_frac && err_c == ERR_NONE |=> res_den_q != '0)
		else $error("fraction result with zero denominator");
`endif

endmodule
